// File: rtl/core/wrsp_pkg.sv
// ----------------------------------------------------------------------------
// wrsp_pkg: shared types and constants of the WAV/RIFF stream parser
// Item and result layouts, parser phases, status codes and header constants.
// ----------------------------------------------------------------------------
`default_nettype none

package wrsp_pkg;

  // Header and chunk constants
  localparam int unsigned HdrLen = 12;
  localparam int unsigned FmtLen = 16;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;  // "fmt " little endian
  localparam logic [31:0] TagData = 32'h6174_6164;  // "data" little endian

  // Result queue depth (power of two, at least 2)
  localparam int unsigned OutDepth = 4;

  // Stream bus widths
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 80;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_END    = 2'd2,
    KIND_CANCEL = 2'd3
  } in_kind_e;

  typedef enum logic [1:0] {
    OUT_PCM    = 2'd0,
    OUT_FORMAT = 2'd1,
    OUT_DONE   = 2'd2,
    OUT_RSVD   = 2'd3
  } out_kind_e;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_TOO_SHORT   = 4'd1,
    ST_NOT_WAVE    = 4'd2,
    ST_BAD_FMT     = 4'd3,
    ST_MISSING     = 4'd4,
    ST_UNSUPPORTED = 4'd5,
    ST_ENDED_SKIP  = 4'd6,
    ST_TRUNCATED   = 4'd7,
    ST_CANCELLED   = 4'd8
  } status_e;

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b0_0000_0001,
    PH_RIFF    = 9'b0_0000_0010,
    PH_CHDR    = 9'b0_0000_0100,
    PH_FMT     = 9'b0_0000_1000,
    PH_FMTSKIP = 9'b0_0001_0000,
    PH_SKIP    = 9'b0_0010_0000,
    PH_PAD     = 9'b0_0100_0000,
    PH_PCM     = 9'b0_1000_0000,
    PH_DRAIN   = 9'b1_0000_0000
  } phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [30:0] declared_length;
  } item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [3:0]  status;
    logic [31:0] audio_bytes;
    logic [31:0] rate_hz;
    logic [7:0]  pcm_byte;
    logic        last;
  } res_t;

  // Up to two results per item, in order r0 then r1
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  // Expected RIFF header byte; chk is low for the size bytes 4..7
  typedef struct packed {
    logic       chk;
    logic [7:0] val;
  } hdr_exp_t;

  function automatic hdr_exp_t hdr_expect(input logic [3:0] idx);
    hdr_exp_t e;
    e = '0;
    case (idx)
      4'd0:  e = '{chk: 1'b1, val: 8'h52};  // R
      4'd1:  e = '{chk: 1'b1, val: 8'h49};  // I
      4'd2:  e = '{chk: 1'b1, val: 8'h46};  // F
      4'd3:  e = '{chk: 1'b1, val: 8'h46};  // F
      4'd8:  e = '{chk: 1'b1, val: 8'h57};  // W
      4'd9:  e = '{chk: 1'b1, val: 8'h41};  // A
      4'd10: e = '{chk: 1'b1, val: 8'h56};  // V
      4'd11: e = '{chk: 1'b1, val: 8'h45};  // E
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/wav_riff_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// wav_riff_stream_parser_unit: byte-serial RIFF/WAVE parser with PCM output
// Checks the RIFF/WAVE header, walks chunks, reads fmt, passes PCM through.
// ----------------------------------------------------------------------------
// Path: a request is registered in the input register, then the parser writes
//   its results into the result queue, whose head drives the output bus; a
//   request waits in the input register while the queue lacks room.
// Throughput: one request per cycle while the result queue has room; the
//   OutDepth-entry result queue absorbs a request's two results, sent in turn.
// Reset: rst_ni low clears the parser to idle and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_riff_stream_parser_unit #(
  parameter int unsigned OutDepth = wrsp_pkg::OutDepth  // power of two, >= 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] data_byte, [38:8] declared_length, [39] zero
  input  logic [wrsp_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]                    s_axis_tuser,
  // result side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] pcm_byte, [39:8] rate_hz, [71:40] audio_bytes,
  // [75:72] status, [79:76] zero
  output logic [wrsp_pkg::OutDataW-1:0] m_axis_tdata,
  // [1:0] out_kind
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast
);
  import wrsp_pkg::*;

  // Input register: holds one request until the queue has room for its
  // results. Ready is high while it is empty or the parser can drain it this cycle.
  logic      in_vld_q, in_vld_d;
  item_t     in_item_q;
  logic      room;
  logic      go;
  logic      s_acc;
  res_pair_t res;
  res_t      head;

  assign go            = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || room;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_acc)   in_vld_d = 1'b1;
    else if (go) in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else         in_vld_q <= in_vld_d;
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_item_q.kind            <= s_axis_tuser;
      in_item_q.data_byte       <= s_axis_tdata[7:0];
      in_item_q.declared_length <= s_axis_tdata[38:8];
    end
  end

  // Parser: state plus combinational update, up to two results per request
  wrsp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .item_i (in_item_q),
    .res_o  (res)
  );

  // Result queue feeding the output bus
  wrsp_out_fifo #(
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res),
    .pop_i   (m_axis_tready),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .head_o  (head)
  );

  assign m_axis_tdata = {4'b0000, head.status, head.audio_bytes,
                         head.rate_hz, head.pcm_byte};
  assign m_axis_tuser = head.out_kind;
  assign m_axis_tlast = head.last;

`ifndef SYNTHESIS
  // back-pressure only while a request is parked
  a_ready_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q)
    else $error("ready low with empty input register");
  // a parked request is not lost while the queue is full
  a_park_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !room) |=> in_vld_q)
    else $error("parked request dropped");
  // no results without a request in the parser
  a_res_needs_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.n != 2'd0 |-> go)
    else $error("results without a request");
`endif

endmodule

`default_nettype wire

// File: rtl/core/wrsp_parser.sv
// ----------------------------------------------------------------------------
// wrsp_parser: RIFF/WAVE parser state and per-item update
// Consumes one item per cycle while go_i is high and produces up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module wrsp_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  go_i,
  input  wrsp_pkg::item_t       item_i,
  output wrsp_pkg::res_pair_t   res_o
);
  import wrsp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [4:0]  idx_q, idx_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] clen_q, clen_d;
  logic [31:0] skip_q, skip_d;
  logic [31:0] bc_q, bc_d;
  logic [30:0] lim_q, lim_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic        seen_q, seen_d;
  logic        hok_q, hok_d;
  logic [31:0] dl_q, dl_d;

  always_comb begin
    logic        active;
    logic        go_hdr;
    logic        chunk_done;
    logic        hdr_cmp;
    logic        fin;
    status_e     fin_st;
    logic        pre;
    res_t        pre_r;
    res_t        done_r;
    logic [31:0] lane;
    logic [32:0] sum;
    logic [31:0] size;
    hdr_exp_t    he;

    phase_d = phase_q;
    idx_d   = idx_q;
    tag_d   = tag_q;
    clen_d  = clen_q;
    skip_d  = skip_q;
    bc_d    = bc_q;
    lim_d   = lim_q;
    fmt_d   = fmt_q;
    chan_d  = chan_q;
    rate_d  = rate_q;
    bits_d  = bits_q;
    seen_d  = seen_q;
    hok_d   = hok_q;
    dl_d    = dl_q;

    active     = (phase_q != PH_IDLE) && (phase_q != PH_DRAIN);
    go_hdr     = 1'b0;
    chunk_done = 1'b0;
    hdr_cmp    = 1'b0;
    fin        = 1'b0;
    fin_st     = ST_OK;
    pre        = 1'b0;
    pre_r      = '0;
    done_r     = '0;
    lane       = {24'h0, item_i.data_byte} << {idx_q[1:0], 3'b000};
    sum        = '0;
    size       = '0;
    he         = hdr_expect(idx_q[3:0]);

    if (go_i) begin
      unique case (in_kind_e'(item_i.kind))
        KIND_START: begin
          if (phase_q != PH_DRAIN) begin
            idx_d  = '0;
            tag_d  = '0;
            clen_d = '0;
            skip_d = '0;
            bc_d   = '0;
            fmt_d  = '0;
            chan_d = '0;
            rate_d = '0;
            bits_d = '0;
            seen_d = 1'b0;
            hok_d  = 1'b1;
            dl_d   = '0;
            lim_d  = item_i.declared_length;
            if (item_i.declared_length != '0 &&
                item_i.declared_length < 31'(HdrLen)) begin
              fin    = 1'b1;
              fin_st = ST_TOO_SHORT;
            end else begin
              phase_d = PH_RIFF;
            end
          end
        end
        KIND_END: begin
          unique case (phase_q)
            PH_RIFF:    begin fin = 1'b1; fin_st = ST_NOT_WAVE;   end
            PH_CHDR:    begin fin = 1'b1; fin_st = ST_MISSING;    end
            PH_FMT:     begin fin = 1'b1; fin_st = ST_BAD_FMT;    end
            PH_FMTSKIP,
            PH_SKIP,
            PH_PAD:     begin fin = 1'b1; fin_st = ST_ENDED_SKIP; end
            PH_PCM:     begin fin = 1'b1; fin_st = ST_TRUNCATED;  end
            default:    fin = 1'b0;
          endcase
        end
        KIND_CANCEL: begin
          if (active) begin
            fin    = 1'b1;
            fin_st = ST_CANCELLED;
          end
        end
        default: begin  // data byte
          if (phase_q == PH_PCM) begin
            pre            = 1'b1;
            pre_r.out_kind = OUT_PCM;
            pre_r.pcm_byte = item_i.data_byte;
            dl_d           = dl_q - 32'd1;
            if (dl_d == '0) begin
              fin    = 1'b1;
              fin_st = ST_OK;
            end
          end else if (active) begin
            bc_d = (bc_q == '1) ? bc_q : bc_q + 32'd1;
            unique case (phase_q)
              PH_RIFF: begin
                if (he.chk && item_i.data_byte != he.val) hok_d = 1'b0;
                idx_d = idx_q + 5'd1;
                if (idx_q == 5'(HdrLen - 1)) begin
                  if (!hok_d) begin
                    fin    = 1'b1;
                    fin_st = ST_NOT_WAVE;
                  end else begin
                    go_hdr = 1'b1;
                  end
                end
              end
              PH_CHDR: begin
                if (idx_q < 5'd4) tag_d = tag_q | lane;
                else              clen_d = clen_q | lane;
                idx_d = idx_q + 5'd1;
                if (idx_q == 5'd7) hdr_cmp = 1'b1;
              end
              PH_FMT: begin
                case (idx_q)
                  5'd0:  fmt_d  = {8'h0, item_i.data_byte};
                  5'd1:  fmt_d  = fmt_q | {item_i.data_byte, 8'h0};
                  5'd2:  chan_d = {8'h0, item_i.data_byte};
                  5'd3:  chan_d = chan_q | {item_i.data_byte, 8'h0};
                  5'd4:  rate_d = {24'h0, item_i.data_byte};
                  5'd5, 5'd6, 5'd7: rate_d = rate_q | lane;
                  5'd14: bits_d = {8'h0, item_i.data_byte};
                  5'd15: bits_d = bits_q | {item_i.data_byte, 8'h0};
                  default: ;
                endcase
                idx_d = idx_q + 5'd1;
                if (idx_q == 5'(FmtLen - 1)) begin
                  seen_d = 1'b1;
                  skip_d = clen_q - 32'(FmtLen);
                  if (skip_d == '0) chunk_done = 1'b1;
                  else              phase_d = PH_FMTSKIP;
                end
              end
              PH_FMTSKIP, PH_SKIP: begin
                skip_d = skip_q - 32'd1;
                if (skip_d == '0) chunk_done = 1'b1;
              end
              PH_PAD:  go_hdr = 1'b1;
              default: ;
            endcase
          end
        end
      endcase
    end

    // chunk header complete
    if (hdr_cmp) begin
      if (tag_d == TagFmt) begin
        if (clen_d < 32'(FmtLen)) begin
          fin    = 1'b1;
          fin_st = ST_BAD_FMT;
        end else begin
          phase_d = PH_FMT;
          idx_d   = '0;
        end
      end else if (tag_d == TagData) begin
        sum  = {1'b0, bc_d} + {1'b0, clen_d};
        size = clen_d;
        if (lim_q != '0 && sum > {2'b00, lim_q}) size = {1'b0, lim_q} - bc_d;
        if (!seen_q) begin
          fin    = 1'b1;
          fin_st = ST_MISSING;
        end else if (fmt_q != 16'd1 || chan_q != 16'd1 || bits_q != 16'd16 ||
                     rate_q == '0) begin
          fin    = 1'b1;
          fin_st = ST_UNSUPPORTED;
        end else begin
          pre               = 1'b1;
          pre_r.out_kind    = OUT_FORMAT;
          pre_r.rate_hz     = rate_q;
          pre_r.audio_bytes = size;
          if (size == '0) begin
            fin    = 1'b1;
            fin_st = ST_OK;
          end else begin
            dl_d    = size;
            phase_d = PH_PCM;
          end
        end
      end else begin
        skip_d = clen_d;
        if (clen_d == '0) chunk_done = 1'b1;
        else              phase_d = PH_SKIP;
      end
    end

    // end of chunk: pad byte on odd size, else next header
    if (chunk_done) begin
      if (clen_d[0]) phase_d = PH_PAD;
      else           go_hdr  = 1'b1;
    end

    if (go_hdr) begin
      idx_d  = '0;
      tag_d  = '0;
      clen_d = '0;
      if (lim_q != '0 && ({1'b0, bc_d} + 33'd8) > {2'b00, lim_q}) begin
        fin    = 1'b1;
        fin_st = ST_MISSING;
      end else begin
        phase_d = PH_CHDR;
      end
    end

    if (fin) phase_d = PH_DRAIN;
    if (go_i && in_kind_e'(item_i.kind) == KIND_END) phase_d = PH_IDLE;

    done_r.out_kind = OUT_DONE;
    done_r.status   = fin_st;
    done_r.last     = 1'b1;

    res_o = '0;
    if (pre && fin) begin
      res_o.n  = 2'd2;
      res_o.r0 = pre_r;
      res_o.r1 = done_r;
    end else if (pre) begin
      res_o.n       = 2'd1;
      res_o.r0      = pre_r;
      res_o.r0.last = 1'b1;
    end else if (fin) begin
      res_o.n  = 2'd1;
      res_o.r0 = done_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      tag_q   <= '0;
      clen_q  <= '0;
      skip_q  <= '0;
      bc_q    <= '0;
      lim_q   <= '0;
      fmt_q   <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
      seen_q  <= 1'b0;
      hok_q   <= 1'b1;
      dl_q    <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      tag_q   <= tag_d;
      clen_q  <= clen_d;
      skip_q  <= skip_d;
      bc_q    <= bc_d;
      lim_q   <= lim_d;
      fmt_q   <= fmt_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      seen_q  <= seen_d;
      hok_q   <= hok_d;
      dl_q    <= dl_d;
    end
  end

`ifndef SYNTHESIS
  // payload countdown never wraps while streaming
  a_pcm_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PCM |-> dl_q != '0)
    else $error("pcm phase with zero bytes left");
`endif

endmodule

`default_nettype wire

// File: rtl/core/wrsp_out_fifo.sv
// ----------------------------------------------------------------------------
// wrsp_out_fifo: result queue
// Takes up to two results per cycle, hands one per cycle to the output bus while it is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module wrsp_out_fifo #(
  parameter int unsigned Depth = wrsp_pkg::OutDepth  // power of two, >= 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wrsp_pkg::res_pair_t push_i,
  input  logic                pop_i,
  output logic                room_o,   // space for two more results
  output logic                valid_o,
  output wrsp_pkg::res_t      head_o
);
  import wrsp_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = pop_i && valid_o;
  assign head_o  = mem_q[rd_q];
  assign room_o  = (cnt_q <= CntW'(Depth - 2));

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.n);
    rd_d  = pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.n) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_q + PtrW'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue count past depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> room_o)
    else $error("results pushed without room");
`endif

endmodule

`default_nettype wire
